>>> hw/rtl/msic_pkg.sv
// Package with opcodes, function codes, trap codes and reset constants of the subset core.
`default_nettype none
package msic_pkg;
    localparam int DATA_WORDS_DEFAULT = 1024;
    localparam logic [31:0] DATA_BASE = 32'h1000_0000;
    localparam logic [31:0] GP_RESET  = 32'h1000_8000;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_TRAP    = 6'h1a;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2b;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_DIV  = 6'h1a;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_SLT  = 6'h2a;

    localparam logic [3:0] TR_NEWLINE = 4'h0;
    localparam logic [3:0] TR_PRINT   = 4'h1;
    localparam logic [3:0] TR_READ    = 4'h5;
    localparam logic [3:0] TR_HALT    = 4'ha;

    localparam logic [1:0] PK_NEWLINE = 2'd0;
    localparam logic [1:0] PK_INT     = 2'd1;
    localparam logic [1:0] PK_PROMPT  = 2'd2;
endpackage
`default_nettype wire

>>> hw/rtl/mips_subset_instruction_core.sv
// Top level of the MIPS subset core: register file, hi/lo, data memory and sequencer.
// Steps: read registers, execute, memory and write back for most instructions; mult adds
// two 32x16 partial products, div one quotient bit a cycle.
// Throughput: one instruction at a time; the next transfer is taken in the cycle after the
// result is registered; a stalled result holds both.
// Reset: pc goes to zero, hi/lo to zero, halt clears; a clearing pass over the larger of
// DATA_WORDS and 32 entries zeroes the data memory and seeds gp and sp, and no item is taken.
`default_nettype none
module mips_subset_instruction_core
    import msic_pkg::*;
#(
    parameter int DATA_WORDS = DATA_WORDS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [31:0]        reset_pc,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [31:0]        instruction,
    input  wire logic [31:0]        read_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [31:0]             next_pc,
    output logic                    print_valid,
    output logic [1:0]              print_kind,
    output logic signed [31:0]      print_value,
    output logic                    halted,
    output logic                    unimplemented,
    output logic                    mem_fault
);
    localparam int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
    localparam logic [33:0] MEM_BYTES = 34'(DATA_WORDS) * 34'd4;
    localparam logic [31:0] SP_RESET = DATA_BASE + MEM_BYTES[31:0];
    // The clearing pass covers both the data memory and all 32 registers.
    localparam int CLR_LAST = ((DATA_WORDS > 32) ? DATA_WORDS : 32) - 1;
    localparam int CW = $clog2(CLR_LAST + 1) + 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_EXEC  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_MULF  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_DIVF  = 4'd7;
    localparam logic [3:0] S_MEM   = 4'd8;
    localparam logic [3:0] S_WB    = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [CW-1:0] clr_reg;
    logic [31:0] pc_reg, hi_reg, lo_reg;
    logic        halt_reg;
    logic [31:0] ins_reg, rdv_reg;

    // memories
    logic [31:0] rf_a [32];
    logic [31:0] rf_b [32];
    logic [31:0] dmem [DATA_WORDS];
    logic [31:0] a_reg, b_reg, dm_q_reg;

    logic        rf_we;
    logic [4:0]  rf_wa;
    logic [31:0] rf_wd;
    logic        dm_we;
    logic [AW-1:0] dm_wa;
    logic [31:0] dm_wd;
    logic        sw_pending_reg;

    // fields
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] simm, uimm, pc4, addr, off;
    assign op   = ins_reg[31:26];
    assign rs   = ins_reg[25:21];
    assign rt   = ins_reg[20:16];
    assign rd   = ins_reg[15:11];
    assign sh   = ins_reg[10:6];
    assign fn   = ins_reg[5:0];
    assign uimm = {16'd0, ins_reg[15:0]};
    assign simm = {{16{ins_reg[15]}}, ins_reg[15:0]};
    assign pc4  = pc_reg + 32'd4;
    assign addr = a_reg + simm;
    assign off  = addr - DATA_BASE;

    logic in_range;
    assign in_range = {2'b00, off} < MEM_BYTES;

    // execute-stage results held until write back
    logic        wen_reg;
    logic [4:0]  wa_reg;
    logic [31:0] wd_reg, npc_reg;
    logic        pv_reg, un_reg, fault_reg, ld_reg;
    logic [1:0]  pk_reg;
    logic [31:0] pval_reg;
    logic [AW-1:0] idx_reg;

    // multiply / divide unit
    logic [31:0] ma_reg, mb_reg;
    logic        neg_reg, rneg_reg;
    logic [63:0] acc_reg;
    logic [31:0] rem_reg;
    logic [5:0]  cnt_reg;

    logic [47:0] pp;
    logic [15:0] mb_half;
    assign mb_half = cnt_reg[0] ? mb_reg[31:16] : mb_reg[15:0];
    assign pp = ma_reg * mb_half;

    logic [32:0] rtrial;
    assign rtrial = {rem_reg, acc_reg[31]} - {1'b0, mb_reg};

    logic out_busy;
    assign out_busy = out_valid && !out_ready;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) || (state_reg == S_CLEAR);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == CW'(CLR_LAST)) state_next = S_IDLE;
            S_IDLE:  if (in_valid) state_next = S_READ;
            S_READ:  state_next = S_EXEC;
            S_EXEC:
            begin
                if (!halt_reg && op == OP_SPECIAL && fn == FN_MULT) state_next = S_MUL;
                else if (!halt_reg && op == OP_SPECIAL && fn == FN_DIV) state_next = S_DIV;
                else state_next = S_MEM;
            end
            S_MUL:   if (cnt_reg == 6'd1) state_next = S_MULF;
            S_MULF:  state_next = S_MEM;
            S_DIV:   if (cnt_reg == 6'd31) state_next = S_DIVF;
            S_DIVF:  state_next = S_MEM;
            S_MEM:   state_next = S_WB;
            S_WB:    if (!out_busy) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    // register file: two copies give two read ports
    always_comb
    begin
        rf_we = 1'b0;
        rf_wa = wa_reg;
        rf_wd = ld_reg ? dm_q_reg : wd_reg;
        if (state_reg == S_CLEAR)
        begin
            rf_we = clr_reg < CW'(32);
            rf_wa = clr_reg[4:0];
            rf_wd = (clr_reg[4:0] == 5'd28) ? GP_RESET :
                    (clr_reg[4:0] == 5'd29) ? SP_RESET : 32'd0;
        end
        else if (state_reg == S_WB && !out_busy)
        begin
            rf_we = wen_reg && (wa_reg != 5'd0) && !(ld_reg && fault_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_a[rf_wa] <= rf_wd;
            rf_b[rf_wa] <= rf_wd;
        end
        if (state_reg == S_IDLE)
        begin
            a_reg <= rf_a[instruction[25:21]];
            b_reg <= rf_b[instruction[20:16]];
        end
    end

    always_comb
    begin
        dm_we = 1'b0;
        dm_wa = idx_reg;
        dm_wd = b_reg;
        if (state_reg == S_CLEAR)
        begin
            dm_we = clr_reg < CW'(DATA_WORDS);
            dm_wa = clr_reg[AW-1:0];
            dm_wd = 32'd0;
        end
        else if (state_reg == S_MEM)
        begin
            dm_we = sw_pending_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dm_we) dmem[dm_wa] <= dm_wd;
        dm_q_reg <= dmem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            pc_reg         <= 32'd0;
            hi_reg         <= 32'd0;
            lo_reg         <= 32'd0;
            halt_reg       <= 1'b0;
            out_valid      <= 1'b0;
            sw_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (cfg_valid && cfg_ready) pc_reg <= reset_pc;
            if (out_valid && out_ready) out_valid <= 1'b0;

            if (state_reg == S_EXEC)
                sw_pending_reg <= !halt_reg && op == OP_SW && in_range;
            if (state_reg == S_MEM) sw_pending_reg <= 1'b0;

            if (state_reg == S_EXEC && !halt_reg && op == OP_TRAP
                && (ins_reg[3:0] != TR_NEWLINE) && (ins_reg[3:0] != TR_PRINT)
                && (ins_reg[3:0] != TR_READ))
                halt_reg <= 1'b1;

            if (state_reg == S_MULF)
            begin
                hi_reg <= neg_reg ? 32'(~acc_reg[63:32] + (acc_reg[31:0] == 32'd0)) :
                                    acc_reg[63:32];
                lo_reg <= neg_reg ? 32'(-acc_reg[31:0]) : acc_reg[31:0];
            end
            if (state_reg == S_DIVF)
            begin
                if (mb_reg == 32'd0)
                begin
                    lo_reg <= 32'hffff_ffff;
                    hi_reg <= rneg_reg ? 32'(-ma_reg) : ma_reg;
                end
                else
                begin
                    lo_reg <= neg_reg ? 32'(-acc_reg[31:0]) : acc_reg[31:0];
                    hi_reg <= rneg_reg ? 32'(-rem_reg) : rem_reg;
                end
            end

            if (state_reg == S_WB && !out_busy)
            begin
                pc_reg    <= npc_reg;
                out_valid <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            ins_reg <= instruction;
            rdv_reg <= read_value;
        end
        if (state_reg == S_EXEC)
        begin
            wen_reg   <= 1'b0;
            wa_reg    <= rd;
            wd_reg    <= 32'd0;
            npc_reg   <= pc4;
            pv_reg    <= 1'b0;
            pk_reg    <= PK_NEWLINE;
            pval_reg  <= 32'd0;
            un_reg    <= 1'b0;
            fault_reg <= 1'b0;
            ld_reg    <= 1'b0;
            idx_reg   <= off[AW+1:2];
            ma_reg    <= a_reg[31] ? 32'(-a_reg) : a_reg;
            mb_reg    <= b_reg[31] ? 32'(-b_reg) : b_reg;
            neg_reg   <= a_reg[31] ^ b_reg[31];
            rneg_reg  <= a_reg[31];
            acc_reg   <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            if (halt_reg)
                npc_reg <= pc_reg;
            else
            begin
                priority case (1'b1)
                    op == OP_SPECIAL:
                    begin
                        priority case (1'b1)
                            fn == FN_SLL:
                            begin wen_reg <= 1'b1; wd_reg <= b_reg << sh; end
                            fn == FN_SRA:
                            begin wen_reg <= 1'b1; wd_reg <= 32'($signed(b_reg) >>> sh); end
                            fn == FN_JR:   npc_reg <= a_reg;
                            fn == FN_MFHI: begin wen_reg <= 1'b1; wd_reg <= hi_reg; end
                            fn == FN_MFLO: begin wen_reg <= 1'b1; wd_reg <= lo_reg; end
                            fn == FN_MULT: ;
                            fn == FN_DIV:
                            begin
                                ma_reg <= b_reg == 32'd0 ? a_reg :
                                          (a_reg[31] ? 32'(-a_reg) : a_reg);
                                rneg_reg <= (b_reg == 32'd0) ? 1'b0 : a_reg[31];
                                acc_reg <= {32'd0, a_reg[31] ? 32'(-a_reg) : a_reg};
                            end
                            fn == FN_ADDU: begin wen_reg <= 1'b1; wd_reg <= a_reg + b_reg; end
                            fn == FN_SUBU: begin wen_reg <= 1'b1; wd_reg <= a_reg - b_reg; end
                            fn == FN_SLT:
                            begin
                                wen_reg <= 1'b1;
                                wd_reg  <= {31'd0, $signed(a_reg) < $signed(b_reg)};
                            end
                            default: un_reg <= 1'b1;
                        endcase
                    end
                    op == OP_J:   npc_reg <= {pc4[31:28], ins_reg[25:0], 2'b00};
                    op == OP_JAL:
                    begin
                        npc_reg <= {pc4[31:28], ins_reg[25:0], 2'b00};
                        wen_reg <= 1'b1; wa_reg <= 5'd31; wd_reg <= pc4;
                    end
                    op == OP_BEQ: if (a_reg == b_reg) npc_reg <= pc4 + (simm << 2);
                    op == OP_BNE: if (a_reg != b_reg) npc_reg <= pc4 + (simm << 2);
                    op == OP_ADDIU: begin wen_reg <= 1'b1; wa_reg <= rt; wd_reg <= addr; end
                    op == OP_ANDI:
                    begin wen_reg <= 1'b1; wa_reg <= rt; wd_reg <= a_reg & uimm; end
                    op == OP_LUI:
                    begin wen_reg <= 1'b1; wa_reg <= rt; wd_reg <= uimm << 16; end
                    op == OP_TRAP:
                    begin
                        priority case (1'b1)
                            ins_reg[3:0] == TR_NEWLINE: pv_reg <= 1'b1;
                            ins_reg[3:0] == TR_PRINT:
                            begin pv_reg <= 1'b1; pk_reg <= PK_INT; pval_reg <= a_reg; end
                            ins_reg[3:0] == TR_READ:
                            begin
                                pv_reg <= 1'b1; pk_reg <= PK_PROMPT;
                                wen_reg <= 1'b1; wa_reg <= rt; wd_reg <= rdv_reg;
                            end
                            ins_reg[3:0] == TR_HALT: ;
                            default: un_reg <= 1'b1;
                        endcase
                    end
                    op == OP_LW:
                    begin
                        wen_reg <= 1'b1; wa_reg <= rt; ld_reg <= 1'b1;
                        fault_reg <= !in_range;
                    end
                    op == OP_SW: fault_reg <= !in_range;
                    default: un_reg <= 1'b1;
                endcase
            end
        end
        if (state_reg == S_MUL)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg[0]) acc_reg <= acc_reg + {pp, 16'd0};
            else            acc_reg <= acc_reg + {16'd0, pp};
        end
        if (state_reg == S_DIV)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (!rtrial[32])
            begin
                rem_reg <= rtrial[31:0];
                acc_reg <= {acc_reg[63:32], acc_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[30:0], acc_reg[31]};
                acc_reg <= {acc_reg[63:32], acc_reg[30:0], 1'b0};
            end
        end
        if (state_reg == S_WB && !out_busy)
        begin
            next_pc       <= npc_reg;
            print_valid   <= pv_reg;
            print_kind    <= pk_reg;
            print_value   <= pval_reg;
            halted        <= halt_reg;
            unimplemented <= un_reg;
            mem_fault     <= fault_reg;
        end
    end
endmodule
`default_nettype wire
